// File: design/dcr_pkg.sv
// shared types and constants for the disk collision resolver
package dcr_pkg;

  localparam int INDEX_BITS = 10;
  localparam int POS_W      = 24;
  localparam int VEL_W      = 16;
  localparam int RAD_W      = 8;
  localparam int DIF_W      = 17;
  localparam int SQ_W       = 2 * DIF_W;
  localparam int ROOT_W     = DIF_W;
  localparam int RS_W       = RAD_W + 1 + 8;
  localparam int FRAC_W     = 16;
  localparam int Q_W        = FRAC_W + 1;
  localparam int U_W        = Q_W + 1;
  localparam int NUM_W      = DIF_W + FRAC_W;

  typedef struct packed {
    logic signed [POS_W-1:0] first_x;
    logic signed [POS_W-1:0] first_y;
    logic signed [VEL_W-1:0] first_vx;
    logic signed [VEL_W-1:0] first_vy;
    logic [RAD_W-1:0]        first_radius;
    logic [INDEX_BITS-1:0]   first_index;
    logic signed [POS_W-1:0] second_x;
    logic signed [POS_W-1:0] second_y;
    logic signed [VEL_W-1:0] second_vx;
    logic signed [VEL_W-1:0] second_vy;
    logic [RAD_W-1:0]        second_radius;
    logic [INDEX_BITS-1:0]   second_index;
  } in_item_t;

  typedef struct packed {
    logic                    hit;
    logic signed [VEL_W-1:0] new_first_vx;
    logic signed [VEL_W-1:0] new_first_vy;
    logic signed [VEL_W-1:0] new_second_vx;
    logic signed [VEL_W-1:0] new_second_vy;
    logic signed [POS_W-1:0] new_second_x;
    logic signed [POS_W-1:0] new_second_y;
  } out_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x1;
    logic signed [POS_W-1:0] y1;
    logic signed [POS_W-1:0] x2;
    logic signed [POS_W-1:0] y2;
    logic signed [VEL_W-1:0] vx1;
    logic signed [VEL_W-1:0] vy1;
    logic signed [VEL_W-1:0] vx2;
    logic signed [VEL_W-1:0] vy2;
    logic [RS_W-1:0]         rs;
    logic                    hit;
    logic                    coinc;
    logic                    sx;
    logic                    sy;
    logic [DIF_W-1:0]        adx;
    logic [DIF_W-1:0]        ady;
  } carry_t;

endpackage

// File: design/dcr_front.sv
// front stages: center deltas, squares and overlap test
module dcr_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              v_i,
  input  dcr_pkg::in_item_t in_i,
  output logic              v_o,
  output dcr_pkg::carry_t   carry_o,
  output logic [dcr_pkg::SQ_W-1:0] dist2_o
);
  import dcr_pkg::*;

  logic [2:0]              v_r;
  carry_t                  c1_r, c1_nxt, c2_r, c2_nxt, c3_r, c3_nxt;
  logic signed [POS_W:0]   dx1_r, dy1_r, dx1_nxt, dy1_nxt;
  logic                    idne_r, idne_nxt;
  logic [POS_W:0]          adx, ady;
  logic [SQ_W-1:0]         sqx_r, sqy_r, rs2_r, sqx_nxt, sqy_nxt, rs2_nxt;
  logic                    cand_r, cand_nxt;
  logic [SQ_W:0]           dist2;
  logic [SQ_W-1:0]         dist2_r, dist2_nxt;

  always_comb begin
    c1_nxt       = '0;
    c1_nxt.x1    = in_i.first_x;
    c1_nxt.y1    = in_i.first_y;
    c1_nxt.x2    = in_i.second_x;
    c1_nxt.y2    = in_i.second_y;
    c1_nxt.vx1   = in_i.first_vx;
    c1_nxt.vy1   = in_i.first_vy;
    c1_nxt.vx2   = in_i.second_vx;
    c1_nxt.vy2   = in_i.second_vy;
    c1_nxt.rs    = {({1'b0, in_i.first_radius} + {1'b0, in_i.second_radius}), 8'b0};
    dx1_nxt      = $signed({in_i.second_x[POS_W-1], in_i.second_x})
                 - $signed({in_i.first_x[POS_W-1], in_i.first_x});
    dy1_nxt      = $signed({in_i.second_y[POS_W-1], in_i.second_y})
                 - $signed({in_i.first_y[POS_W-1], in_i.first_y});
    idne_nxt     = in_i.first_index != in_i.second_index;

    adx          = dx1_r[POS_W] ? $unsigned(-dx1_r) : $unsigned(dx1_r);
    ady          = dy1_r[POS_W] ? $unsigned(-dy1_r) : $unsigned(dy1_r);
    sqx_nxt      = adx[DIF_W-1:0] * adx[DIF_W-1:0];
    sqy_nxt      = ady[DIF_W-1:0] * ady[DIF_W-1:0];
    rs2_nxt      = c1_r.rs * c1_r.rs;
    cand_nxt     = idne_r && !(|adx[POS_W:DIF_W]) && !(|ady[POS_W:DIF_W]);
    c2_nxt       = c1_r;
    c2_nxt.adx   = adx[DIF_W-1:0];
    c2_nxt.ady   = ady[DIF_W-1:0];
    c2_nxt.sx    = dx1_r[POS_W];
    c2_nxt.sy    = dy1_r[POS_W];

    dist2        = {1'b0, sqx_r} + {1'b0, sqy_r};
    c3_nxt       = c2_r;
    c3_nxt.hit   = cand_r && (dist2 < {1'b0, rs2_r});
    c3_nxt.coinc = dist2 == '0;
    dist2_nxt    = dist2[SQ_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[1:0], v_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r    <= c1_nxt;
      dx1_r   <= dx1_nxt;
      dy1_r   <= dy1_nxt;
      idne_r  <= idne_nxt;
      sqx_r   <= sqx_nxt;
      sqy_r   <= sqy_nxt;
      rs2_r   <= rs2_nxt;
      cand_r  <= cand_nxt;
      c2_r    <= c2_nxt;
      c3_r    <= c3_nxt;
      dist2_r <= dist2_nxt;
    end
  end

  assign v_o     = v_r[2];
  assign carry_o = c3_r;
  assign dist2_o = dist2_r;

endmodule

// File: design/dcr_sqrt.sv
// pipelined integer square root, one result bit per stage
module dcr_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       v_i,
  input  logic [dcr_pkg::SQ_W-1:0]   rad_i,
  input  dcr_pkg::carry_t            carry_i,
  output logic                       v_o,
  output logic [dcr_pkg::ROOT_W-1:0] root_o,
  output dcr_pkg::carry_t            carry_o
);
  import dcr_pkg::*;

  logic [ROOT_W-1:0] v_r;
  logic [SQ_W:0]     rem_r [ROOT_W];
  logic [SQ_W:0]     res_r [ROOT_W];
  logic [SQ_W:0]     rem_nxt [ROOT_W];
  logic [SQ_W:0]     res_nxt [ROOT_W];
  carry_t            c_r [ROOT_W];

  always_comb begin
    logic [SQ_W:0] rin, qin, bitv, trial;
    for (int k = 0; k < ROOT_W; k++) begin
      rin   = (k == 0) ? {1'b0, rad_i} : rem_r[(k == 0) ? 0 : k - 1];
      qin   = (k == 0) ? '0 : res_r[(k == 0) ? 0 : k - 1];
      bitv  = (SQ_W + 1)'(1) << (2 * (ROOT_W - 1 - k));
      trial = qin + bitv;
      if (rin >= trial) begin
        rem_nxt[k] = rin - trial;
        res_nxt[k] = (qin >> 1) + bitv;
      end else begin
        rem_nxt[k] = rin;
        res_nxt[k] = qin >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[ROOT_W-2:0], v_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < ROOT_W; k++) begin
        rem_r[k] <= rem_nxt[k];
        res_r[k] <= res_nxt[k];
        c_r[k]   <= (k == 0) ? carry_i : c_r[(k == 0) ? 0 : k - 1];
      end
    end
  end

  assign v_o     = v_r[ROOT_W-1];
  assign root_o  = res_r[ROOT_W-1][ROOT_W-1:0];
  assign carry_o = c_r[ROOT_W-1];

endmodule

// File: design/dcr_div.sv
// pipelined restoring divider for both unit vector lanes
module dcr_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       v_i,
  input  logic [dcr_pkg::ROOT_W-1:0] den_i,
  input  dcr_pkg::carry_t            carry_i,
  output logic                       v_o,
  output logic [dcr_pkg::Q_W-1:0]    qx_o,
  output logic [dcr_pkg::Q_W-1:0]    qy_o,
  output dcr_pkg::carry_t            carry_o
);
  import dcr_pkg::*;

  logic [Q_W-1:0]    v_r;
  logic [NUM_W-1:0]  rem_r [2][Q_W];
  logic [Q_W-1:0]    q_r [2][Q_W];
  logic [NUM_W-1:0]  rem_nxt [2][Q_W];
  logic [Q_W-1:0]    q_nxt [2][Q_W];
  logic [ROOT_W-1:0] den_r [Q_W];
  carry_t            c_r [Q_W];
  logic [NUM_W-1:0]  num [2];

  assign num[0] = {carry_i.adx, FRAC_W'(0)};
  assign num[1] = {carry_i.ady, FRAC_W'(0)};

  always_comb begin
    logic [NUM_W-1:0]  rin;
    logic [Q_W-1:0]    qin;
    logic [ROOT_W-1:0] din;
    logic [NUM_W:0]    sh;
    for (int l = 0; l < 2; l++) begin
      for (int k = 0; k < Q_W; k++) begin
        rin = (k == 0) ? num[l] : rem_r[l][(k == 0) ? 0 : k - 1];
        qin = (k == 0) ? '0 : q_r[l][(k == 0) ? 0 : k - 1];
        din = (k == 0) ? den_i : den_r[(k == 0) ? 0 : k - 1];
        sh  = (NUM_W + 1)'(din) << (Q_W - 1 - k);
        if ({1'b0, rin} >= sh) begin
          rem_nxt[l][k] = rin - sh[NUM_W-1:0];
          q_nxt[l][k]   = qin | (Q_W'(1) << (Q_W - 1 - k));
        end else begin
          rem_nxt[l][k] = rin;
          q_nxt[l][k]   = qin;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[Q_W-2:0], v_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < Q_W; k++) begin
        for (int l = 0; l < 2; l++) begin
          rem_r[l][k] <= rem_nxt[l][k];
          q_r[l][k]   <= q_nxt[l][k];
        end
        den_r[k] <= (k == 0) ? den_i : den_r[(k == 0) ? 0 : k - 1];
        c_r[k]   <= (k == 0) ? carry_i : c_r[(k == 0) ? 0 : k - 1];
      end
    end
  end

  assign v_o     = v_r[Q_W-1];
  assign qx_o    = q_r[0][Q_W-1];
  assign qy_o    = q_r[1][Q_W-1];
  assign carry_o = c_r[Q_W-1];

endmodule

// File: design/dcr_back.sv
// back stages: unit vector, projection, velocity exchange and placement
module dcr_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    v_i,
  input  logic [dcr_pkg::Q_W-1:0] qx_i,
  input  logic [dcr_pkg::Q_W-1:0] qy_i,
  input  dcr_pkg::carry_t         carry_i,
  output logic                    v_o,
  output dcr_pkg::out_item_t      out_o
);
  import dcr_pkg::*;

  localparam int DV_W = VEL_W + 1;
  localparam int PX_W = DV_W + U_W;
  localparam int S_W  = PX_W + 1;
  localparam int RX_W = RS_W + 1 + U_W;
  localparam int T_W  = RX_W - FRAC_W;
  localparam int MX_W = S_W + U_W;
  localparam int DS_W = MX_W - 2 * FRAC_W;
  localparam int SV_W = DS_W + 1;

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W:0] v);
    if (v[POS_W] != v[POS_W-1]) begin
      return {v[POS_W], {(POS_W-1){~v[POS_W]}}};
    end
    return v[POS_W-1:0];
  endfunction

  function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [SV_W-1:0] v);
    if ((&v[SV_W-1:VEL_W-1]) || !(|v[SV_W-1:VEL_W-1])) begin
      return v[VEL_W-1:0];
    end
    return {v[SV_W-1], {(VEL_W-1){~v[SV_W-1]}}};
  endfunction

  logic [4:0]              v_r;
  carry_t                  cu_r, c1_r, c2_r, c3_r;
  logic signed [U_W-1:0]   ux_r, uy_r, ux1_r, uy1_r, ux2_r, uy2_r;
  logic signed [U_W-1:0]   ux_nxt, uy_nxt;
  logic signed [DV_W-1:0]  dvx, dvy;
  logic signed [PX_W-1:0]  px_r, py_r, px_nxt, py_nxt;
  logic signed [RX_W-1:0]  rx_r, ry_r, rx_nxt, ry_nxt;
  logic signed [S_W-1:0]   s_r, s_nxt;
  logic signed [RX_W-1:0]  rxb, ryb;
  logic signed [POS_W-1:0] nx_r, ny_r, nx_nxt, ny_nxt, nx3_r, ny3_r;
  logic signed [MX_W-1:0]  mx_r, my_r, mx_nxt, my_nxt, mxb, myb;
  logic signed [DS_W-1:0]  dsx, dsy;
  out_item_t               out_r, out_nxt;

  always_comb begin
    if (carry_i.coinc) begin
      ux_nxt = U_W'(1) << FRAC_W;
      uy_nxt = '0;
    end else begin
      ux_nxt = carry_i.sx ? -$signed({1'b0, qx_i}) : $signed({1'b0, qx_i});
      uy_nxt = carry_i.sy ? -$signed({1'b0, qy_i}) : $signed({1'b0, qy_i});
    end

    dvx    = $signed({cu_r.vx2[VEL_W-1], cu_r.vx2}) - $signed({cu_r.vx1[VEL_W-1], cu_r.vx1});
    dvy    = $signed({cu_r.vy2[VEL_W-1], cu_r.vy2}) - $signed({cu_r.vy1[VEL_W-1], cu_r.vy1});
    px_nxt = dvx * ux_r;
    py_nxt = dvy * uy_r;
    rx_nxt = $signed({1'b0, cu_r.rs}) * ux_r;
    ry_nxt = $signed({1'b0, cu_r.rs}) * uy_r;

    s_nxt  = $signed({px_r[PX_W-1], px_r}) + $signed({py_r[PX_W-1], py_r});
    rxb    = rx_r + $signed({{(RX_W-FRAC_W){1'b0}}, {FRAC_W{rx_r[RX_W-1]}}});
    ryb    = ry_r + $signed({{(RX_W-FRAC_W){1'b0}}, {FRAC_W{ry_r[RX_W-1]}}});
    nx_nxt = sat_pos($signed({c1_r.x1[POS_W-1], c1_r.x1})
                   + (POS_W + 1)'($signed(rxb[RX_W-1:FRAC_W])));
    ny_nxt = sat_pos($signed({c1_r.y1[POS_W-1], c1_r.y1})
                   + (POS_W + 1)'($signed(ryb[RX_W-1:FRAC_W])));

    mx_nxt = s_r * ux2_r;
    my_nxt = s_r * uy2_r;

    mxb    = mx_r + $signed({{(MX_W-2*FRAC_W){1'b0}}, {(2*FRAC_W){mx_r[MX_W-1]}}});
    myb    = my_r + $signed({{(MX_W-2*FRAC_W){1'b0}}, {(2*FRAC_W){my_r[MX_W-1]}}});
    dsx    = mxb[MX_W-1:2*FRAC_W];
    dsy    = myb[MX_W-1:2*FRAC_W];
    out_nxt.hit = c3_r.hit;
    if (c3_r.hit) begin
      out_nxt.new_first_vx  = sat_vel(SV_W'(c3_r.vx1) + SV_W'(dsx));
      out_nxt.new_first_vy  = sat_vel(SV_W'(c3_r.vy1) + SV_W'(dsy));
      out_nxt.new_second_vx = sat_vel(SV_W'(c3_r.vx2) - SV_W'(dsx));
      out_nxt.new_second_vy = sat_vel(SV_W'(c3_r.vy2) - SV_W'(dsy));
      out_nxt.new_second_x  = nx3_r;
      out_nxt.new_second_y  = ny3_r;
    end else begin
      out_nxt.new_first_vx  = c3_r.vx1;
      out_nxt.new_first_vy  = c3_r.vy1;
      out_nxt.new_second_vx = c3_r.vx2;
      out_nxt.new_second_vy = c3_r.vy2;
      out_nxt.new_second_x  = c3_r.x2;
      out_nxt.new_second_y  = c3_r.y2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[3:0], v_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cu_r  <= carry_i;
      ux_r  <= ux_nxt;
      uy_r  <= uy_nxt;
      c1_r  <= cu_r;
      ux1_r <= ux_r;
      uy1_r <= uy_r;
      px_r  <= px_nxt;
      py_r  <= py_nxt;
      rx_r  <= rx_nxt;
      ry_r  <= ry_nxt;
      c2_r  <= c1_r;
      ux2_r <= ux1_r;
      uy2_r <= uy1_r;
      s_r   <= s_nxt;
      nx_r  <= nx_nxt;
      ny_r  <= ny_nxt;
      c3_r  <= c2_r;
      mx_r  <= mx_nxt;
      my_r  <= my_nxt;
      nx3_r <= nx_r;
      ny3_r <= ny_r;
      out_r <= out_nxt;
    end
  end

  assign v_o   = v_r[4];
  assign out_o = out_r;

endmodule

// File: design/disk_collision_resolve_core.sv
// top level of the disk pair collision resolver
//
// usage:
//   in_valid/in_ready/in_data carry one disk pair request per cycle;
//   out_valid/out_ready/out_data carry one result per request, in order.
//   a pair collides when the indices differ and the center distance is
//   below the radius sum; velocities along the line of centers are then
//   exchanged and the second disk is placed touching the first.
// pipeline stages from request to result:
//   3 front stages, 17 square root stages, 17 divider stages,
//   5 projection and output stages.
// throughput: one request per cycle while the output is not stalled,
//   set by the fully pipelined square root and divider.
// reset: synchronous, clears all valid bits; the pipe comes up empty.
// stall: when out_valid is high and out_ready is low the whole pipe
//   holds and in_ready drops; nothing is lost or repeated.
module disk_collision_resolve_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dcr_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dcr_pkg::out_item_t  out_data
);
  import dcr_pkg::*;

  logic              en;
  logic              f_v, s_v, d_v;
  carry_t            f_c, s_c, d_c;
  logic [SQ_W-1:0]   f_dist2;
  logic [ROOT_W-1:0] s_root;
  logic [Q_W-1:0]    d_qx, d_qy;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  dcr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .v_i     (in_valid && in_ready),
    .in_i    (in_data),
    .v_o     (f_v),
    .carry_o (f_c),
    .dist2_o (f_dist2)
  );

  dcr_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .v_i     (f_v),
    .rad_i   (f_dist2),
    .carry_i (f_c),
    .v_o     (s_v),
    .root_o  (s_root),
    .carry_o (s_c)
  );

  dcr_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .v_i     (s_v),
    .den_i   (s_root),
    .carry_i (s_c),
    .v_o     (d_v),
    .qx_o    (d_qx),
    .qy_o    (d_qy),
    .carry_o (d_c)
  );

  dcr_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .v_i     (d_v),
    .qx_i    (d_qx),
    .qy_i    (d_qy),
    .carry_i (d_c),
    .v_o     (out_valid),
    .out_o   (out_data)
  );

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without a waiting result");

  a_hold_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(f_dist2) && $stable(s_root)))
    else $error("pipe moved during an output stall");

endmodule
